FILE: rtl/vau_pkg.sv
// Package for the four-component vector arithmetic unit.
// Holds operation codes, widths, the pipeline item type and the result type.
// No dependencies; every other file in rtl/ but vau_if.sv imports it.
package vau_pkg;

   localparam int LANES      = 4;
   localparam int DATA_W     = 32;
   localparam int SQ_SRC_W   = 62;
   localparam int ROOT_W     = 31;
   localparam int SQ_REM_W   = 34;
   localparam int SQRT_STEPS = SQ_SRC_W / 2;
   localparam int FRAC_W     = 16;
   localparam int NQ_W       = DATA_W + FRAC_W;
   localparam int DREM_W     = DATA_W + 1;
   localparam int DIV_STEPS  = NQ_W;

   localparam logic [3:0] FUNC_ADD  = 4'd0;
   localparam logic [3:0] FUNC_SUB  = 4'd1;
   localparam logic [3:0] FUNC_MUL  = 4'd2;
   localparam logic [3:0] FUNC_DIV  = 4'd3;
   localparam logic [3:0] FUNC_ADDS = 4'd4;
   localparam logic [3:0] FUNC_SUBS = 4'd5;
   localparam logic [3:0] FUNC_MULS = 4'd6;
   localparam logic [3:0] FUNC_DIVS = 4'd7;
   localparam logic [3:0] FUNC_LEN  = 4'd8;
   localparam logic [3:0] FUNC_NORM = 4'd9;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

   // One item as it travels down the pipeline.
   typedef struct packed {
      logic [3:0]                          func;
      logic [LANES-1:0][DATA_W-1:0]        amag;
      logic [LANES-1:0]                    aneg;
      logic [LANES-1:0][DATA_W-1:0]        dmag;
      logic [LANES-1:0]                    dneg;
      logic [LANES-1:0][DATA_W-1:0]        res;
      logic [LANES-1:0]                    sat;
      logic [LANES-1:0]                    dz;
      logic [SQ_SRC_W-1:0]                 sq_src;
      logic [SQ_REM_W-1:0]                 sq_rem;
      logic [ROOT_W-1:0]                   root;
      logic                                capped;
      logic [LANES-1:0][NQ_W-1:0]          nq;
      logic [LANES-1:0][DREM_W-1:0]        drem;
   } vau_item_type;

   typedef struct packed {
      logic [LANES-1:0][DATA_W-1:0] r;
      logic                         div_zero;
      logic                         saturated;
   } vau_rsp_type;

endpackage

FILE: rtl/vau_if.sv
// Valid/ready channel interfaces of the vector arithmetic unit.
// Request carries the operation and two vectors, response the result vector and flags.
// No dependencies.
interface vau_req_if;
   logic               valid;
   logic               ready;
   logic        [3:0]  func;
   logic signed [31:0] a_x;
   logic signed [31:0] a_y;
   logic signed [31:0] a_z;
   logic signed [31:0] a_w;
   logic signed [31:0] b_x;
   logic signed [31:0] b_y;
   logic signed [31:0] b_z;
   logic signed [31:0] b_w;

   modport source (output valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                   input ready);
   modport sink   (input valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                   output ready);
endinterface

interface vau_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] r_x;
   logic signed [31:0] r_y;
   logic signed [31:0] r_z;
   logic signed [31:0] r_w;
   logic               div_zero;
   logic               saturated;

   modport source (output valid, r_x, r_y, r_z, r_w, div_zero, saturated,
                   input ready);
   modport sink   (input valid, r_x, r_y, r_z, r_w, div_zero, saturated,
                   output ready);
endinterface

FILE: rtl/vau_front.sv
// Front end of the vector arithmetic unit: multiplies, add/sub/mul results,
// sum of squares and set-up of the square root and divider chains. Uses vau_pkg.
module vau_front import vau_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [3:0]                   in_func,
   input  logic [LANES-1:0][DATA_W-1:0] in_a,
   input  logic [LANES-1:0][DATA_W-1:0] in_b,
   output logic                         out_valid,
   output vau_item_type                 out_item
);

   // Stage one: operand selection, multipliers, add and subtract.
   logic                              s1_valid_ff;
   logic [3:0]                        s1_func_ff;
   logic [LANES-1:0][DATA_W-1:0]      s1_amag_ff, s1_amag_in;
   logic [LANES-1:0]                  s1_aneg_ff, s1_aneg_in;
   logic [LANES-1:0][DATA_W-1:0]      s1_dmag_ff, s1_dmag_in;
   logic [LANES-1:0]                  s1_dneg_ff, s1_dneg_in;
   logic [LANES-1:0][63:0]            s1_prod_ff, s1_prod_in;
   logic [LANES-1:0][DATA_W:0]        s1_as_ff, s1_as_in;

   logic                              is_len;
   logic                              is_scalar;
   logic [DATA_W-1:0]                 beff;
   logic [DATA_W-1:0]                 op2;

   always_comb begin
      is_len    = (in_func == FUNC_LEN) || (in_func == FUNC_NORM);
      is_scalar = (in_func[3:2] == 2'b01);
      beff      = '0;
      op2       = '0;
      for (int i = 0; i < LANES; i++) begin
         beff = is_scalar ? in_b[0] : in_b[i];
         op2  = is_len ? in_a[i] : beff;
         s1_prod_in[i] = $signed(in_a[i]) * $signed(op2);
         if (in_func[1:0] == OP_SUB) begin
            s1_as_in[i] = {in_a[i][DATA_W-1], in_a[i]} - {beff[DATA_W-1], beff};
         end else begin
            s1_as_in[i] = {in_a[i][DATA_W-1], in_a[i]} + {beff[DATA_W-1], beff};
         end
         s1_aneg_in[i] = in_a[i][DATA_W-1];
         s1_amag_in[i] = in_a[i][DATA_W-1] ? (~in_a[i] + 1'b1) : in_a[i];
         s1_dneg_in[i] = beff[DATA_W-1];
         s1_dmag_in[i] = beff[DATA_W-1] ? (~beff + 1'b1) : beff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
      if (en) begin
         s1_func_ff <= in_func;
         s1_amag_ff <= s1_amag_in;
         s1_aneg_ff <= s1_aneg_in;
         s1_dmag_ff <= s1_dmag_in;
         s1_dneg_ff <= s1_dneg_in;
         s1_prod_ff <= s1_prod_in;
         s1_as_ff   <= s1_as_in;
      end
   end

   // Stage two: rounding and clamping of the elementwise results, pair sums.
   logic                s2_valid_ff;
   vau_item_type        s2_item_ff, s2_item_in;
   logic [63:0]         s2_sq01_ff, s2_sq01_in;
   logic [63:0]         s2_sq23_ff, s2_sq23_in;
   logic [63:0]         rnd;
   logic [NQ_W-1:0]     sh;

   always_comb begin
      s2_item_in      = '0;
      s2_item_in.func = s1_func_ff;
      s2_item_in.amag = s1_amag_ff;
      s2_item_in.aneg = s1_aneg_ff;
      s2_item_in.dmag = s1_dmag_ff;
      s2_item_in.dneg = s1_dneg_ff;
      s2_sq01_in = {1'b0, s1_prod_ff[0][62:0]} + {1'b0, s1_prod_ff[1][62:0]};
      s2_sq23_in = {1'b0, s1_prod_ff[2][62:0]} + {1'b0, s1_prod_ff[3][62:0]};
      rnd = '0;
      sh  = '0;
      for (int i = 0; i < LANES; i++) begin
         rnd = s1_prod_ff[i] + 64'd32768;
         sh  = rnd[63:FRAC_W];
         if (s1_func_ff[3] == 1'b0) begin
            case (s1_func_ff[1:0])
               OP_ADD, OP_SUB: begin
                  if (s1_as_ff[i][DATA_W] != s1_as_ff[i][DATA_W-1]) begin
                     s2_item_in.sat[i] = 1'b1;
                     s2_item_in.res[i] = s1_as_ff[i][DATA_W] ? Q_MIN : Q_MAX;
                  end else begin
                     s2_item_in.res[i] = s1_as_ff[i][DATA_W-1:0];
                  end
               end
               OP_MUL: begin
                  if ((&sh[NQ_W-1:DATA_W-1]) || !(|sh[NQ_W-1:DATA_W-1])) begin
                     s2_item_in.res[i] = sh[DATA_W-1:0];
                  end else begin
                     s2_item_in.sat[i] = 1'b1;
                     s2_item_in.res[i] = sh[NQ_W-1] ? Q_MIN : Q_MAX;
                  end
               end
               default: begin
                  // Division: only the zero divisor is settled here.
                  if (s1_dmag_ff[i] == '0) begin
                     s2_item_in.dz[i]  = 1'b1;
                     s2_item_in.res[i] = s1_aneg_ff[i] ? Q_MIN : Q_MAX;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_item_ff <= s2_item_in;
         s2_sq01_ff <= s2_sq01_in;
         s2_sq23_ff <= s2_sq23_in;
      end
   end

   // Stage three: total sum of squares, cap check and chain initial values.
   logic                s3_valid_ff;
   vau_item_type        s3_item_ff, s3_item_in;
   logic [64:0]         total;

   always_comb begin
      total             = {1'b0, s2_sq01_ff} + {1'b0, s2_sq23_ff};
      s3_item_in        = s2_item_ff;
      s3_item_in.capped = |total[64:SQ_SRC_W];
      s3_item_in.sq_src = total[SQ_SRC_W-1:0];
      s3_item_in.sq_rem = '0;
      s3_item_in.root   = '0;
      for (int i = 0; i < LANES; i++) begin
         s3_item_in.nq[i]   = {s2_item_ff.amag[i], {FRAC_W{1'b0}}};
         s3_item_in.drem[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (en) begin
         s3_item_ff <= s3_item_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_item_ff;

endmodule

FILE: rtl/vau_sqrt_cell.sv
// One cell of the square root chain: resolves one root bit from two radicand bits.
// Uses vau_pkg.
module vau_sqrt_cell import vau_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  vau_item_type in_item,
   output logic         out_valid,
   output vau_item_type out_item
);

   logic                valid_ff;
   vau_item_type        item_ff, item_in;
   logic [SQ_REM_W-1:0] rem2;
   logic [SQ_REM_W-1:0] trial;
   logic                ge;

   always_comb begin
      rem2  = {in_item.sq_rem[SQ_REM_W-3:0], in_item.sq_src[SQ_SRC_W-1 -: 2]};
      trial = {1'b0, in_item.root, 2'b01};
      ge    = (rem2 >= trial);
      item_in        = in_item;
      item_in.sq_rem = ge ? (rem2 - trial) : rem2;
      item_in.root   = {in_item.root[ROOT_W-2:0], ge};
      item_in.sq_src = {in_item.sq_src[SQ_SRC_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

FILE: rtl/vau_div_cell.sv
// One cell of the divider chain: one restoring quotient bit for each of the four lanes.
// Uses vau_pkg.
module vau_div_cell import vau_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  vau_item_type in_item,
   output logic         out_valid,
   output vau_item_type out_item
);

   logic              valid_ff;
   vau_item_type      item_ff, item_in;
   logic [DREM_W-1:0] rem2;
   logic              ge;

   always_comb begin
      item_in = in_item;
      rem2    = '0;
      ge      = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         rem2 = {in_item.drem[i][DREM_W-2:0], in_item.nq[i][NQ_W-1]};
         ge   = (rem2 >= {1'b0, in_item.dmag[i]});
         item_in.drem[i] = ge ? (rem2 - {1'b0, in_item.dmag[i]}) : rem2;
         item_in.nq[i]   = {in_item.nq[i][NQ_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

FILE: rtl/vec4_arith_unit_core.sv
// Top level of the four-component vector arithmetic unit in signed Q16.16.
// Uses vau_pkg, vau_if, vau_front, vau_sqrt_cell and vau_div_cell.
//
// This unit takes one request item per clock and returns one response item per
// request, in order. Each item carries an operation code and two vectors A and B;
// the unit performs elementwise add, subtract, multiply or divide of A by B or by
// the scalar B.x, the length of A (in r_x, other components zero) or A normalized.
// Every operation runs through the same fixed pipeline, from an accepted request to
// its response: three front stages, a chain of 31 square root cells (one root bit
// each), a chain of 48 divider cells (one quotient bit each, all four components
// side by side) and the output register. Throughput is one item per cycle as long
// as responses are taken. The output has a second holding register, so when the
// response side stalls the pipeline keeps advancing until an item must go into the
// holding register; req_ch.ready drops in the cycle after that. ready is a register
// and does not depend combinationally on rsp_ch.ready. Results clamp to the signed
// 32-bit range and raise saturated; a zero divisor gives the signed maximum or
// minimum and raises div_zero, and normalizing a zero vector gives zero with div_zero.
module vec4_arith_unit_core import vau_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   vau_req_if.sink       req_ch,
   vau_rsp_if.source     rsp_ch
);

   // The whole pipeline moves together while the holding register is empty.
   logic skid_valid_ff;
   logic en;

   assign en           = !skid_valid_ff;
   assign req_ch.ready = en;

   logic [LANES-1:0][DATA_W-1:0] in_a;
   logic [LANES-1:0][DATA_W-1:0] in_b;

   assign in_a = {req_ch.a_w, req_ch.a_z, req_ch.a_y, req_ch.a_x};
   assign in_b = {req_ch.b_w, req_ch.b_z, req_ch.b_y, req_ch.b_x};

   logic         sq_valid [0:SQRT_STEPS];
   vau_item_type sq_item  [0:SQRT_STEPS];

   vau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .in_func   (req_ch.func),
      .in_a      (in_a),
      .in_b      (in_b),
      .out_valid (sq_valid[0]),
      .out_item  (sq_item[0])
   );

   // Square root chain: each cell settles one bit of floor(sqrt(sum of squares)).
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      vau_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_valid[k]),
         .in_item   (sq_item[k]),
         .out_valid (sq_valid[k+1]),
         .out_item  (sq_item[k+1])
      );
   end

   // Once the root is known, the length result is placed and, for a normalize,
   // the length becomes the divisor of all four components.
   logic         dv_valid [0:DIV_STEPS];
   vau_item_type dv_item  [0:DIV_STEPS];
   vau_item_type setup;
   logic [DATA_W-1:0] len;

   always_comb begin
      setup = sq_item[SQRT_STEPS];
      len   = setup.capped ? Q_MAX : {1'b0, setup.root};
      if (setup.func == FUNC_LEN) begin
         setup.res[0] = len;
         setup.sat[0] = setup.capped;
      end else if (setup.func == FUNC_NORM) begin
         for (int i = 0; i < LANES; i++) begin
            setup.dmag[i] = len;
            setup.dneg[i] = 1'b0;
            setup.dz[i]   = (len == '0);
         end
      end
   end

   assign dv_valid[0] = sq_valid[SQRT_STEPS];
   assign dv_item[0]  = setup;

   // Divider chain: one quotient bit per cell for all four components.
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      vau_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dv_valid[k]),
         .in_item   (dv_item[k]),
         .out_valid (dv_valid[k+1]),
         .out_item  (dv_item[k+1])
      );
   end

   // Sign and clamp of the quotients, then the flags are gathered over the lanes.
   vau_item_type      tail;
   vau_rsp_type       tail_rsp;
   logic              is_div;
   logic              neg;
   logic [NQ_W-1:0]   q;

   always_comb begin
      tail     = dv_item[DIV_STEPS];
      is_div   = (tail.func == FUNC_DIV) || (tail.func == FUNC_DIVS) ||
                 (tail.func == FUNC_NORM);
      neg      = 1'b0;
      q        = '0;
      tail_rsp = '0;
      for (int i = 0; i < LANES; i++) begin
         tail_rsp.r[i] = tail.res[i];
         q   = tail.nq[i];
         neg = (tail.func == FUNC_NORM) ? tail.aneg[i] : (tail.aneg[i] ^ tail.dneg[i]);
         if (is_div && !tail.dz[i]) begin
            if (!neg) begin
               if (|q[NQ_W-1:DATA_W-1]) begin
                  tail.sat[i]   = 1'b1;
                  tail_rsp.r[i] = Q_MAX;
               end else begin
                  tail_rsp.r[i] = q[DATA_W-1:0];
               end
            end else begin
               if ((|q[NQ_W-1:DATA_W]) || (q[DATA_W-1] && (|q[DATA_W-2:0]))) begin
                  tail.sat[i]   = 1'b1;
                  tail_rsp.r[i] = Q_MIN;
               end else begin
                  tail_rsp.r[i] = ~q[DATA_W-1:0] + 1'b1;
               end
            end
         end
      end
      tail_rsp.div_zero  = |tail.dz;
      tail_rsp.saturated = |tail.sat;
   end

   // Output register with one holding register behind it.
   logic        out_valid_ff;
   vau_rsp_type out_ff;
   vau_rsp_type skid_ff;
   logic        push;
   logic        pop;

   assign push = en && dv_valid[DIV_STEPS];
   assign pop  = out_valid_ff && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || pop) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= push;
            end
         end else if (push) begin
            skid_valid_ff <= 1'b1;
         end
      end
      if (!out_valid_ff || pop) begin
         out_ff <= skid_valid_ff ? skid_ff : tail_rsp;
      end else if (push) begin
         skid_ff <= tail_rsp;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.r_x       = out_ff.r[0];
   assign rsp_ch.r_y       = out_ff.r[1];
   assign rsp_ch.r_z       = out_ff.r[2];
   assign rsp_ch.r_w       = out_ff.r[3];
   assign rsp_ch.div_zero  = out_ff.div_zero;
   assign rsp_ch.saturated = out_ff.saturated;

endmodule

FILE: tb/vec4_arith_unit_core_tb.sv
// Self-checking testbench for vec4_arith_unit_core, the Q16.16 vector arithmetic unit.
// Depends on vau_pkg and the vau_req_if / vau_rsp_if interfaces in rtl/.
module vec4_arith_unit_core_tb import vau_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY   = 83;
   localparam int WDOG_MAX  = 4000;
   localparam longint SMAX  = 64'sd2147483647;
   localparam longint SMIN  = -64'sd2147483648;

   typedef struct {
      logic [3:0]         func;
      logic signed [31:0] a [4];
      logic signed [31:0] b [4];
   } vec_op_type;

   typedef struct {
      logic signed [31:0] r [4];
      logic               dz;
      logic               sat;
   } vec_res_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vau_req_if req_ch ();
   vau_rsp_if rsp_ch ();

   vec4_arith_unit_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Expected results, oldest first.
   vec_res_type expected_q [$];
   int       mismatches = 0;
   int       wdog = 0;
   bit       calm = 1'b0;     // When set, neither side idles.
   logic     rsp_ready_r = 1'b0;

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.func  <= '0;
      req_ch.a_x <= '0; req_ch.a_y <= '0; req_ch.a_z <= '0; req_ch.a_w <= '0;
      req_ch.b_x <= '0; req_ch.b_y <= '0; req_ch.b_z <= '0; req_ch.b_w <= '0;
   end
   assign rsp_ch.ready = rsp_ready_r;

   function automatic longint clamp_q(longint v, inout bit sat);
      if (v > SMAX) begin
         sat = 1'b1;
         return SMAX;
      end
      if (v < SMIN) begin
         sat = 1'b1;
         return SMIN;
      end
      return v;
   endfunction

   // Floor of (p + 2^15) / 2^16: arithmetic shift rounds toward minus infinity.
   function automatic longint round_q_mul(longint a, longint b);
      longint p;
      p = a * b + 64'sd32768;
      return p >>> 16;
   endfunction

   // Integer square root by the classic bit-pair method.
   function automatic longint int_sqrt(logic [63:0] n);
      logic [63:0] root, bits;
      root = 0;
      bits = 64'd1 << 62;
      while (bits > n) bits = bits >> 2;
      while (bits != 0) begin
         if (n >= root + bits) begin
            n    = n - (root + bits);
            root = (root >> 1) + bits;
         end else begin
            root = root >> 1;
         end
         bits = bits >> 2;
      end
      return longint'(root);
   endfunction

   function automatic longint vec_len(vec_op_type op, inout bit sat);
      logic [63:0] s, m;
      longint      c;
      s = 0;
      for (int i = 0; i < 4; i++) begin
         c = op.a[i];
         m = (c < 0) ? -c : c;
         s = s + m * m;
         if (s >= (64'd1 << 62)) s = 64'd1 << 62;
      end
      if (s >= (64'd1 << 62)) begin
         sat = 1'b1;
         return SMAX;
      end
      return int_sqrt(s);
   endfunction

   function automatic vec_res_type predict_vec(vec_op_type op);
      vec_res_type res;
      longint   a, b, v, len;
      bit       sat, dz, len_sat;
      sat = 0;
      dz  = 0;
      for (int i = 0; i < 4; i++) res.r[i] = '0;
      if (op.func <= FUNC_DIVS) begin
         for (int i = 0; i < 4; i++) begin
            a = op.a[i];
            b = (op.func >= FUNC_ADDS) ? longint'(op.b[0]) : longint'(op.b[i]);
            case (op.func[1:0])
               OP_ADD: v = clamp_q(a + b, sat);
               OP_SUB: v = clamp_q(a - b, sat);
               OP_MUL: v = clamp_q(round_q_mul(a, b), sat);
               default: begin
                  if (b == 0) begin
                     dz = 1;
                     v  = (a >= 0) ? SMAX : SMIN;
                  end else begin
                     v = clamp_q((a * 64'sd65536) / b, sat);
                  end
               end
            endcase
            res.r[i] = v[31:0];
         end
      end else if (op.func == FUNC_LEN) begin
         v = vec_len(op, sat);
         res.r[0] = v[31:0];
      end else if (op.func == FUNC_NORM) begin
         len_sat = 0;
         len = vec_len(op, len_sat);
         if (len == 0) begin
            dz = 1;
         end else begin
            for (int i = 0; i < 4; i++) begin
               a = op.a[i];
               v = clamp_q((a * 64'sd65536) / len, sat);
               res.r[i] = v[31:0];
            end
         end
      end
      res.dz  = dz;
      res.sat = sat;
      return res;
   endfunction

   function automatic bit idle_now();
      return !calm && ($urandom_range(99) < 21);
   endfunction

   // Sends one item, idling at random beforehand, and records its expected result.
   // Valid stays high after a handshake so that items can follow back to back;
   // it drops only while the sender idles or drains.
   task automatic send_op(vec_op_type op);
      while (idle_now()) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func  <= op.func;
      req_ch.a_x <= op.a[0]; req_ch.a_y <= op.a[1];
      req_ch.a_z <= op.a[2]; req_ch.a_w <= op.a[3];
      req_ch.b_x <= op.b[0]; req_ch.b_y <= op.b[1];
      req_ch.b_z <= op.b[2]; req_ch.b_w <= op.b[3];
      do @(posedge clock); while (!req_ch.ready);
      expected_q.push_back(predict_vec(op));
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return '0;
         3: return 32'(int'($urandom_range(262143)) - 131072);
         4: return 32'h0001_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic vec_op_type rand_op(int func_max);
      vec_op_type op;
      op.func = 4'($urandom_range(func_max));
      for (int i = 0; i < 4; i++) begin
         op.a[i] = rand_word();
         op.b[i] = rand_word();
      end
      return op;
   endfunction

   function automatic vec_op_type make_op(logic [3:0] f, logic [31:0] av, logic [31:0] bv);
      vec_op_type op;
      op.func = f;
      for (int i = 0; i < 4; i++) begin
         op.a[i] = av;
         op.b[i] = bv;
      end
      return op;
   endfunction

   // Response side: random stalls, and every accepted item is checked in order.
   always @(posedge clock) begin
      vec_res_type exp_r;
      if (reset) begin
         rsp_ready_r <= 1'b0;
      end else begin
         rsp_ready_r <= !idle_now();
         if (rsp_ch.valid && rsp_ready_r) begin
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result item r_x=%h", rsp_ch.r_x);
            end else begin
               exp_r = expected_q.pop_front();
               if (rsp_ch.r_x !== exp_r.r[0] || rsp_ch.r_y !== exp_r.r[1] ||
                   rsp_ch.r_z !== exp_r.r[2] || rsp_ch.r_w !== exp_r.r[3] ||
                   rsp_ch.div_zero !== exp_r.dz || rsp_ch.saturated !== exp_r.sat) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %h %h %h %h dz=%b sat=%b got %h %h %h %h dz=%b sat=%b",
                        exp_r.r[0], exp_r.r[1], exp_r.r[2], exp_r.r[3], exp_r.dz, exp_r.sat,
                        rsp_ch.r_x, rsp_ch.r_y, rsp_ch.r_z, rsp_ch.r_w,
                        rsp_ch.div_zero, rsp_ch.saturated);
               end
            end
         end
      end
   end

   // Watchdog: any cycle without a handshake on either side counts toward the limit.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ready_r) || reset)
         wdog <= 0;
      else
         wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
         $display("vec4_arith_unit_core_tb: done, errors");
         $finish;
      end
   end

   // Extremes of every field and every operation, including unused codes.
   task automatic test_extremes();
      logic [31:0] vals [5];
      vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000, 32'hFFFF_FFFF};
      for (int f = 0; f < 16; f++)
         send_op(make_op(4'(f), vals[f % 5], vals[(f + 2) % 5]));
   endtask

   // Divide by zero, zero-length and tiny normalize, length overflow and a saturating scalar multiply.
   task automatic test_special();
      vec_op_type op;
      send_op(make_op(FUNC_DIV, 32'h0001_0000, 32'h0));
      send_op(make_op(FUNC_DIV, 32'hFFFF_0000, 32'h0));
      send_op(make_op(FUNC_DIVS, 32'h0, 32'h0));
      send_op(make_op(FUNC_NORM, 32'h0, 32'h0));
      send_op(make_op(FUNC_LEN, 32'h8000_0000, 32'h0));
      send_op(make_op(FUNC_NORM, 32'h7FFF_FFFF, 32'h0));
      op = make_op(FUNC_NORM, 32'h0, 32'h0);
      op.a[2] = 32'h0000_0001;
      send_op(op);
      op = make_op(FUNC_MULS, 32'h7FFF_FFFF, 32'h0);
      op.b[0] = 32'h8000_0000;
      send_op(op);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_random(int count, int func_max);
      for (int n = 0; n < count; n++) send_op(rand_op(func_max));
   endtask

   // Back-to-back stretch with no idling on either side.
   task automatic test_streaming();
      calm = 1'b1;
      test_random(300, 9);
      calm = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_special();
      drain();                 // Sender holds off until every result is back.
      test_random(800, 9);
      test_streaming();
      test_random(800, 15);
      drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("vec4_arith_unit_core_tb: done, clean");
      end else begin
         $display("vec4_arith_unit_core_tb: done, errors");
      end
      $finish;
   end
endmodule

FILE: sim.f
rtl/vau_pkg.sv
rtl/vau_if.sv
rtl/vau_front.sv
rtl/vau_sqrt_cell.sv
rtl/vau_div_cell.sv
rtl/vec4_arith_unit_core.sv
tb/vec4_arith_unit_core_tb.sv
